@@ rtl/bbc2_pkg.sv @@
package bbc2_pkg;

  // Item and arithmetic formats
  localparam int CHANNELS     = 2;
  localparam int SAMPLE_BITS  = 24;
  localparam int STATE_BITS   = 40;
  localparam int FRAC_BITS    = 16;
  localparam int CF_BITS      = 20;
  localparam int CF_FRAC      = 18;
  localparam int GAIN_BITS    = 32;
  localparam int GAIN_FRAC    = 31;
  localparam int GSH_BITS     = 6;
  localparam int NUM_COEF     = 16;
  localparam int NUM_ROWS     = 16;   // one delay pair per (section, channel)
  localparam int ROW_BITS     = 4;
  localparam int CIDX_BITS    = 4;
  localparam int PROD_BITS    = CF_BITS + STATE_BITS;
  localparam int ACC_BITS     = PROD_BITS + 2;
  localparam int GPROD_BITS   = SAMPLE_BITS + GAIN_BITS;
  localparam int Y_BITS       = STATE_BITS + 3;
  localparam int FIN_BITS     = STATE_BITS + 1;
  localparam int SH_BITS      = 7;
  localparam int SH_MAX       = 62;
  localparam int TDATA_BITS   = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 3 * CF_BITS;
  localparam int NUM_REGS      = 8;

  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN  = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SHIFT = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CP0   = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CP4   = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_CP5   = 4'd7;

  // Schedule: job j = (section j/2, channel j%2)
  localparam int NUM_JOBS = 2 * 8;
  localparam int T_BITS   = 6;
  localparam int LAST_T   = 2 * NUM_JOBS + 2;

  localparam logic signed [63:0] ST_MAX  = (64'sd1 <<< (STATE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] ST_MIN  = -ST_MAX - 64'sd1;
  localparam logic signed [63:0] SMP_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SMP_MIN = -SMP_MAX - 64'sd1;

  typedef struct packed {
    logic signed [STATE_BITS-1:0] w1;
    logic signed [STATE_BITS-1:0] w2;
  } dly_t;

  // Per-cycle commands from the sequencer to the datapath
  typedef struct packed {
    logic                 load_in;
    logic                 gmul;
    logic                 gmul_ch;
    logic                 gfin;
    logic                 gfin_ch;
    logic                 rd;
    logic [ROW_BITS-1:0]  rd_row;
    logic                 m1;
    logic                 m2;
    logic                 m2_ch;
    logic [CIDX_BITS-1:0] cidx;
    logic                 wst;
    logic                 yst;
    logic [ROW_BITS-1:0]  y_row;
    logic                 fin;
  } cmd_t;

  // Clip to state width; top bit is the clip flag
  function automatic logic [STATE_BITS:0] sat_state(input logic signed [63:0] v);
    logic [STATE_BITS:0] r;
    if (v > ST_MAX) r = {1'b1, ST_MAX[STATE_BITS-1:0]};
    else if (v < ST_MIN) r = {1'b1, ST_MIN[STATE_BITS-1:0]};
    else r = {1'b0, v[STATE_BITS-1:0]};
    return r;
  endfunction

  // Clip to sample width; top bit is the clip flag
  function automatic logic [SAMPLE_BITS:0] sat_sample(input logic signed [63:0] v);
    logic [SAMPLE_BITS:0] r;
    if (v > SMP_MAX) r = {1'b1, SMP_MAX[SAMPLE_BITS-1:0]};
    else if (v < SMP_MIN) r = {1'b1, SMP_MIN[SAMPLE_BITS-1:0]};
    else r = {1'b0, v[SAMPLE_BITS-1:0]};
    return r;
  endfunction

endpackage

@@ rtl/bbc2_ctrl.sv @@
module bbc2_ctrl import bbc2_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [T_BITS-1:0] t_q, t_d;
  logic              out_vld_q, out_vld_d;
  logic              run, fin, accept;
  logic [4:0]        j_m2, j_y;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign accept      = in_valid_i && in_ready_o;
  assign run         = (state_q == ST_RUN);
  assign fin         = (state_q == ST_DONE) && (!out_vld_q || out_ready_i);

  // Sequencer state
  always_comb begin
    state_d = state_q;
    t_d     = t_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
          t_d     = '0;
        end
      end
      ST_RUN: begin
        t_d = t_q + T_BITS'(1);
        if (t_q == T_BITS'(LAST_T)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (fin) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result register handshake
  always_comb begin
    out_vld_d = out_vld_q;
    if (fin) out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      t_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      t_q       <= t_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Job indices for the second multiply and the output stage
  assign j_m2 = t_q[5:1] - 5'd1;
  assign j_y  = t_q[5:1] - 5'd2;

  // Command decode from the cycle count
  always_comb begin
    cmd_o         = '0;
    cmd_o.load_in = accept;
    cmd_o.fin     = fin;
    cmd_o.gmul    = run && (t_q <= T_BITS'(1));
    cmd_o.gmul_ch = t_q[0];
    cmd_o.gfin    = run && (t_q >= T_BITS'(1)) && (t_q <= T_BITS'(2));
    cmd_o.gfin_ch = t_q[1];
    cmd_o.rd      = run && !t_q[0] && (t_q < T_BITS'(2 * NUM_JOBS));
    cmd_o.rd_row  = t_q[4:1];
    cmd_o.m1      = run && t_q[0] && (t_q < T_BITS'(2 * NUM_JOBS));
    cmd_o.m2      = run && !t_q[0] && (t_q >= T_BITS'(2))
                    && (t_q <= T_BITS'(2 * NUM_JOBS));
    cmd_o.m2_ch   = j_m2[0];
    // first multiply uses coefficient 2s+1, second 2s+2 (zero based here)
    cmd_o.cidx    = t_q[0] ? {t_q[4:2], 1'b0} : {j_m2[3:1], 1'b1};
    cmd_o.wst     = run && t_q[0] && (t_q >= T_BITS'(3));
    cmd_o.yst     = run && !t_q[0] && (t_q >= T_BITS'(4));
    cmd_o.y_row   = j_y[3:0];
  end

endmodule

@@ rtl/bbc2_dp.sv @@
module bbc2_dp import bbc2_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  input  logic [TDATA_BITS-1:0]    in_data_i,
  input  logic                     in_last_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output logic [TDATA_BITS-1:0]    out_data_o,
  output logic                     out_sat_o,
  output logic                     out_last_o
);

  // Configuration registers
  logic signed [GAIN_BITS-1:0] gain_q;
  logic [GSH_BITS-1:0]         gsh_q;
  logic signed [CF_BITS-1:0]   coef_q [NUM_COEF];
  logic [CIDX_BITS-1:0]        cbase;
  logic                        reg_hit;

  assign cbase   = CIDX_BITS'(cfg_index_i - REG_CP0) * CIDX_BITS'(3);
  assign reg_hit = cfg_we_i && (cfg_index_i < CFG_IDX_BITS'(NUM_REGS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= '0;
      gsh_q  <= '0;
      for (int k = 0; k < NUM_COEF; k++) coef_q[k] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i) inside
        REG_GAIN:  gain_q <= cfg_data_i[GAIN_BITS-1:0];
        REG_SHIFT: gsh_q  <= cfg_data_i[GSH_BITS-1:0];
        [REG_CP0:REG_CP4]: begin
          for (int j = 0; j < 3; j++) begin
            coef_q[cbase + CIDX_BITS'(j)] <= cfg_data_i[j*CF_BITS +: CF_BITS];
          end
        end
        REG_CP5:   coef_q[NUM_COEF-1] <= cfg_data_i[CF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input item registers
  logic signed [SAMPLE_BITS-1:0] smp_q [CHANNELS];
  logic                          eob_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      smp_q[0] <= in_data_i[SAMPLE_BITS-1:0];
      smp_q[1] <= in_data_i[2*SAMPLE_BITS-1:SAMPLE_BITS];
      eob_q    <= in_last_i;
    end
  end

  // Delay pair memory: one row per (section, channel), valid bits give zero
  dly_t                dly_mem [NUM_ROWS];
  logic [NUM_ROWS-1:0] vld_q;
  dly_t                rd_q;
  logic                rd_vld_q;
  dly_t                rd_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (reg_hit) vld_q <= '0;
      else if (cmd_i.yst) vld_q[cmd_i.y_row] <= 1'b1;
      if (cmd_i.rd) rd_vld_q <= vld_q[cmd_i.rd_row];
    end
  end

  assign rd_word = rd_vld_q ? rd_q : '0;

  // Gain stage: multiply, then rounded shift and clip; zero when the total shift exceeds SH_MAX
  logic signed [GPROD_BITS-1:0] gp_q;
  logic [SH_BITS-1:0]           gsh_tot;
  logic signed [63:0]           gsum, gshr;
  logic [STATE_BITS:0]          gsat;
  logic signed [STATE_BITS-1:0] gx;
  logic                         gclip;

  assign gsh_tot = SH_BITS'(GAIN_FRAC - FRAC_BITS) + SH_BITS'(gsh_q);

  always_comb begin
    gsum  = 64'(gp_q) + (64'sd1 <<< (gsh_tot - SH_BITS'(1)));
    gshr  = gsum >>> gsh_tot;
    gsat  = sat_state(gshr);
    gx    = gsat[STATE_BITS-1:0];
    gclip = gsat[STATE_BITS];
    if (gsh_tot > SH_BITS'(SH_MAX)) begin
      gx    = '0;
      gclip = 1'b0;
    end
  end

  // Shared feedback multiplier
  logic signed [CF_BITS-1:0]    coef_sel;
  logic signed [STATE_BITS-1:0] mul_dat;
  logic signed [PROD_BITS-1:0]  p_d, p_q;
  dly_t                         hold_q, yw_q;

  assign coef_sel = coef_q[cmd_i.cidx];
  assign mul_dat  = cmd_i.m1 ? rd_word.w2 : hold_q.w1;
  assign p_d      = coef_sel * mul_dat;

  // Accumulate: x scaled up with rounding bias, minus both products
  localparam logic signed [ACC_BITS-1:0] ROUND_CF = ACC_BITS'(1) <<< (CF_FRAC - 1);

  logic signed [STATE_BITS-1:0] x_q [CHANNELS];
  logic signed [ACC_BITS-1:0]   acc_d, acc_q, diff;
  logic [STATE_BITS:0]          wsat;
  logic signed [STATE_BITS-1:0] w_q;

  assign acc_d = (ACC_BITS'(x_q[cmd_i.m2_ch]) <<< CF_FRAC) + ROUND_CF - ACC_BITS'(p_q);
  assign diff  = acc_q - ACC_BITS'(p_q);
  assign wsat  = sat_state(64'(diff >>> CF_FRAC));

  // Section output: w2 -+ 2*w1 + w; lower four sections subtract
  logic signed [Y_BITS-1:0] y_sum;
  logic [STATE_BITS:0]      ysat;

  always_comb begin
    if (cmd_i.y_row[ROW_BITS-1])
      y_sum = Y_BITS'(yw_q.w2) + (Y_BITS'(yw_q.w1) <<< 1) + Y_BITS'(w_q);
    else
      y_sum = Y_BITS'(yw_q.w2) - (Y_BITS'(yw_q.w1) <<< 1) + Y_BITS'(w_q);
  end
  assign ysat = sat_state(64'(y_sum));

  // Final rounding to sample width, per channel
  logic signed [FIN_BITS-1:0] fsum [CHANNELS];
  logic [SAMPLE_BITS:0]       fsat [CHANNELS];

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      fsum[c] = FIN_BITS'(x_q[c]) + (FIN_BITS'(1) <<< (FRAC_BITS - 1));
      fsat[c] = sat_sample(64'(fsum[c] >>> FRAC_BITS));
    end
  end

  // Datapath registers
  logic flag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_q <= dly_mem[cmd_i.rd_row];
    if (cmd_i.yst) dly_mem[cmd_i.y_row] <= '{w1: w_q, w2: yw_q.w1};
    if (cmd_i.gmul) gp_q <= smp_q[cmd_i.gmul_ch] * gain_q;
    if (cmd_i.m1 || cmd_i.m2) p_q <= p_d;
    if (cmd_i.m1) hold_q <= rd_word;
    if (cmd_i.m2) begin
      acc_q <= acc_d;
      yw_q  <= hold_q;
    end
    if (cmd_i.wst) w_q <= wsat[STATE_BITS-1:0];
    if (cmd_i.gfin) x_q[cmd_i.gfin_ch] <= gx;
    else if (cmd_i.yst) x_q[cmd_i.y_row[0]] <= ysat[STATE_BITS-1:0];
  end

  // Clip flag gathered over the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (cmd_i.load_in) begin
      flag_q <= 1'b0;
    end else begin
      flag_q <= flag_q | (cmd_i.gfin & gclip) | (cmd_i.wst & wsat[STATE_BITS])
                | (cmd_i.yst & ysat[STATE_BITS]);
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_data_o <= {{(TDATA_BITS - CHANNELS * SAMPLE_BITS){1'b0}},
                     fsat[1][SAMPLE_BITS-1:0], fsat[0][SAMPLE_BITS-1:0]};
      out_sat_o  <= flag_q | fsat[0][SAMPLE_BITS] | fsat[1][SAMPLE_BITS];
      out_last_o <= eob_q;
    end
  end

endmodule

@@ rtl/butterworth_biquad_cascade_2ch_unit.sv @@
// Channel   Dir  Handshake                    Content
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: sample_a, sample_b; tlast: end_of_block
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: filtered_a, filtered_b; tuser: saturated;
//                                             tlast: block_end
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i register index, cfg_data_i value
//
// An item passes through the accept, the section schedule and the loading of the result
// register. The shared 20x40 feedback multiplier sets the pace: two products per section and
// channel, 32 per item, with the jobs issued in turn and the channels interleaved.
// Reset clears control, configuration and the delay-row valid bits (delay words read zero).
// A waiting result sits in the output register; the next item is accepted meanwhile, and
// the block holds its finished result until that register is free.
module butterworth_biquad_cascade_2ch_unit import bbc2_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [TDATA_BITS-1:0]    s_axis_tdata,   // sample_a, sample_b
  input  logic                     s_axis_tlast,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [TDATA_BITS-1:0]    m_axis_tdata,   // filtered_a, filtered_b
  output logic                     m_axis_tuser,   // saturated
  output logic                     m_axis_tlast,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  cmd_t cmd;

  // Registers take writes only while no item is being filtered
  assign cfg_ready_o = s_axis_tready;

  bbc2_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  bbc2_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (m_axis_tdata),
    .out_sat_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

@@ rtl/bbc2_chk.sv @@
module bbc2_chk import bbc2_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [TDATA_BITS-1:0]    m_axis_tdata,
  input logic                     m_axis_tuser,
  input logic                     m_axis_tlast,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // One item at a time: input closes right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input still open after accept");

  // No result appears the cycle after an accept
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result too early");

  // A new result comes with the input side open again
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("input closed after result");

  // Register writes land only between items
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |-> s_axis_tready)
    else $error("register write during an item");

endmodule

bind butterworth_biquad_cascade_2ch_unit bbc2_chk u_bbc2_chk (.*);

@@ test/butterworth_biquad_cascade_2ch_unit_tb.sv @@
import bbc2_pkg::*;

// One filtered sample pair as it should leave the block
typedef struct {
  logic signed [SAMPLE_BITS-1:0] filtered_a;
  logic signed [SAMPLE_BITS-1:0] filtered_b;
  logic                          saturated;
  logic                          block_end;
} filtered_pair_t;

// Bit-exact model of both biquad cascades plus the queue of pairs still to come out
class biquad_tracker;
  logic signed [GAIN_BITS-1:0]  gain;
  logic [GSH_BITS-1:0]          gain_sh;
  logic signed [CF_BITS-1:0]    coef [NUM_COEF+1];
  logic signed [STATE_BITS-1:0] dly [CHANNELS][NUM_ROWS];
  filtered_pair_t               awaited [$];
  bit                           clipped;
  int                           errors;

  function new();
    gain    = '0;
    gain_sh = '0;
    errors  = 0;
    foreach (coef[i]) coef[i] = '0;
    clear_delays();
  endfunction

  function void clear_delays();
    foreach (dly[c, i]) dly[c][i] = '0;
  endfunction

  // Clip to a signed width, remember that it happened
  function longint clip(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clipped = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clipped = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Round to nearest, ties up, then drop sh bits
  function longint round_shift(longint v, int sh);
    return (v + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  // Gain stage and eight sections for one channel
  function longint filter_channel(int ch, longint smp);
    longint x, w2, w1, acc, w, y;
    int sh, s;
    sh = GAIN_FRAC - FRAC_BITS + int'(gain_sh);
    if (sh > SH_MAX) x = 0;
    else x = clip(round_shift(smp * longint'(gain), sh), STATE_BITS);
    for (s = 0; s < 8; s++) begin
      w2  = dly[ch][2*s];
      w1  = dly[ch][2*s+1];
      acc = x * (longint'(1) <<< CF_FRAC)
          - longint'(coef[2*s+1]) * w2
          - longint'(coef[2*s+2]) * w1;
      w   = clip(round_shift(acc, CF_FRAC), STATE_BITS);
      // first half high-pass numerator, second half low-pass
      y   = (s < 4) ? (w2 - 2 * w1 + w) : (w2 + 2 * w1 + w);
      dly[ch][2*s]   = STATE_BITS'(w1);
      dly[ch][2*s+1] = STATE_BITS'(w);
      x   = clip(y, STATE_BITS);
    end
    return clip(round_shift(x, FRAC_BITS), SAMPLE_BITS);
  endfunction

  // Accepted input pair: compute its filtered pair
  function void note_input(logic [SAMPLE_BITS-1:0] a, logic [SAMPLE_BITS-1:0] b, logic eob);
    filtered_pair_t p;
    clipped      = 1'b0;
    p.filtered_a = SAMPLE_BITS'(filter_channel(0, longint'(signed'(a))));
    p.filtered_b = SAMPLE_BITS'(filter_channel(1, longint'(signed'(b))));
    p.saturated  = clipped;
    p.block_end  = eob;
    awaited.push_back(p);
  endfunction

  // Accepted result: compare with the oldest pending pair
  function void check_result(logic [TDATA_BITS-1:0] data, logic user, logic last);
    filtered_pair_t p;
    if (awaited.size() == 0) begin
      $error("result with no item pending: tdata %h tuser %b tlast %b", data, user, last);
      errors++;
      return;
    end
    p = awaited.pop_front();
    if (data[SAMPLE_BITS-1:0] !== p.filtered_a) begin
      $error("filtered_a expected %0d actual %0d", p.filtered_a,
             $signed(data[SAMPLE_BITS-1:0]));
      errors++;
    end
    if (data[2*SAMPLE_BITS-1:SAMPLE_BITS] !== p.filtered_b) begin
      $error("filtered_b expected %0d actual %0d", p.filtered_b,
             $signed(data[2*SAMPLE_BITS-1:SAMPLE_BITS]));
      errors++;
    end
    if (user !== p.saturated) begin
      $error("saturated expected %b actual %b", p.saturated, user);
      errors++;
    end
    if (last !== p.block_end) begin
      $error("block_end expected %b actual %b", p.block_end, last);
      errors++;
    end
  endfunction

  // Register write; any known index also flushes the delay line
  function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    int base;
    if (idx >= NUM_REGS) return;
    if (idx == REG_GAIN) gain = value[GAIN_BITS-1:0];
    else if (idx == REG_SHIFT) gain_sh = value[GSH_BITS-1:0];
    else if (idx == REG_CP5) coef[NUM_COEF] = value[CF_BITS-1:0];
    else begin
      base = 3 * int'(idx - REG_CP0) + 1;
      for (int j = 0; j < 3; j++) coef[base + j] = value[CF_BITS*j +: CF_BITS];
    end
    clear_delays();
  endfunction
endclass

module butterworth_biquad_cascade_2ch_unit_tb;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = SMP_MAX[SAMPLE_BITS-1:0];
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = SMP_MIN[SAMPLE_BITS-1:0];
  localparam logic signed [GAIN_BITS-1:0]   G_MAX = 32'sh7fff_ffff;
  localparam logic signed [GAIN_BITS-1:0]   G_MIN = 32'sh8000_0000;
  localparam logic signed [CF_BITS-1:0]     C_MAX = 20'sh7ffff;
  localparam logic signed [CF_BITS-1:0]     C_MIN = 20'sh80000;
  localparam logic [CFG_IDX_BITS-1:0]       IDX_TOP = '1;
  localparam int                            ITEM_GOAL = 1550;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [TDATA_BITS-1:0]    s_axis_tdata;   // sample_a, sample_b
  logic                     s_axis_tlast;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [TDATA_BITS-1:0]    m_axis_tdata;   // filtered_a, filtered_b
  logic                     m_axis_tuser;   // saturated
  logic                     m_axis_tlast;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  biquad_tracker             tracker = new();
  bit                        quiet = 1'b0;   // no idling on either side while set
  int                        items_sent = 0;
  logic signed [CF_BITS-1:0] coef_set [1:NUM_COEF];

  butterworth_biquad_cascade_2ch_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result sink with random stalls
  initial begin : result_sink
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      tracker.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // Send one sample pair; entered and left at a falling edge
  task automatic send_pair(logic signed [SAMPLE_BITS-1:0] a, logic signed [SAMPLE_BITS-1:0] b,
                           logic eob);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tlast  <= eob;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_input(a, b, eob);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending and let every pending pair come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (tracker.awaited.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // One register write; valid is left high for back-to-back writes
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, value);
    @(negedge clk_i);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] junk60();
    return CFG_DATA_BITS'({$urandom, $urandom});
  endfunction

  // Write an unknown register index; must leave the filter untouched
  task automatic poke_unknown();
    write_reg(CFG_IDX_BITS'($urandom_range(NUM_REGS, IDX_TOP)), junk60());
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Write all registers from gain, shift and coef_set; unused upper bits get noise
  task automatic load_filter(logic signed [GAIN_BITS-1:0] g, logic [GSH_BITS-1:0] sh);
    logic [CFG_DATA_BITS-1:0] word;
    word = junk60();
    write_reg(REG_GAIN, {word[CFG_DATA_BITS-1:GAIN_BITS], g});
    word = junk60();
    write_reg(REG_SHIFT, {word[CFG_DATA_BITS-1:GSH_BITS], sh});
    for (int i = 0; i <= int'(REG_CP4 - REG_CP0); i++)
      write_reg(REG_CP0 + CFG_IDX_BITS'(i),
                {coef_set[3*i+3], coef_set[3*i+2], coef_set[3*i+1]});
    word = junk60();
    write_reg(REG_CP5, {word[CFG_DATA_BITS-1:CF_BITS], coef_set[NUM_COEF]});
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic fill_coefs(logic signed [CF_BITS-1:0] v);
    foreach (coef_set[i]) coef_set[i] = v;
  endtask

  // Poles inside the unit circle: a2 = r^2, a1 = -2 r cos(theta)
  task automatic pick_stable_coefs();
    longint r, c;
    for (int s = 0; s < 8; s++) begin
      r = $urandom_range(131072, 255000);
      c = longint'($urandom_range(0, 524286)) - 262143;
      coef_set[2*s+1] = CF_BITS'((r * r) >>> CF_FRAC);
      coef_set[2*s+2] = CF_BITS'(-((2 * r * c) >>> CF_FRAC));
    end
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return S_MAX;
      1:       return S_MIN;
      2, 3:    return SAMPLE_BITS'(int'($urandom_range(0, 2047)) - 1024);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Stimulus
  initial begin : stimulus
    logic signed [GAIN_BITS-1:0] g;
    logic [GSH_BITS-1:0]         sh;
    int                          n;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: zero gain, nothing gets through
    send_pair(S_MAX, S_MIN, 1'b1);
    send_pair(S_MIN, S_MAX, 1'b0);
    send_pair('0, -1, 1'b0);
    drain();

    // Gain of -1, no feedback: min times min clips the gain stage
    fill_coefs('0);
    load_filter(G_MIN, '0);
    send_pair(S_MIN, S_MIN, 1'b0);
    send_pair(S_MAX, 1, 1'b1);
    send_pair('0, '0, 1'b0);
    send_pair(-1, 1, 1'b0);
    drain();
    // Unknown index keeps the delay words
    poke_unknown();
    send_pair(1, -1, 1'b0);
    send_pair('0, '0, 1'b1);
    drain();

    // Total shift at the limit, then beyond it (gain stage gives zero)
    load_filter(G_MAX, GSH_BITS'(SH_MAX - (GAIN_FRAC - FRAC_BITS)));
    send_pair(S_MAX, S_MIN, 1'b0);
    drain();
    load_filter(G_MAX, '1);
    send_pair(S_MAX, S_MIN, 1'b1);
    drain();

    // Extreme feedback: state clips
    fill_coefs(C_MAX);
    load_filter(G_MAX, '0);
    send_pair(S_MAX, S_MAX, 1'b0);
    send_pair(S_MIN, S_MIN, 1'b0);
    send_pair(S_MAX, S_MIN, 1'b0);
    drain();
    fill_coefs(C_MIN);
    load_filter(G_MIN, '0);
    send_pair(S_MAX, 1, 1'b0);
    send_pair(S_MIN, -1, 1'b1);
    drain();

    // A stable filter with a moderate gain
    pick_stable_coefs();
    load_filter(32'sh1000_0000, 6'd12);
    send_pair(1000, -1000, 1'b0);
    send_pair('0, '0, 1'b0);
    send_pair(S_MAX, S_MIN, 1'b0);
    send_pair(-5, 5, 1'b1);
    drain();

    // Random phases, each with its own settings
    while (items_sent < ITEM_GOAL) begin
      case ($urandom_range(0, 9))
        0:       fill_coefs('0);
        1:       fill_coefs(C_MAX);
        2:       fill_coefs(C_MIN);
        3, 4:    foreach (coef_set[i]) coef_set[i] = CF_BITS'($urandom);
        default: pick_stable_coefs();
      endcase
      case ($urandom_range(0, 5))
        0: begin
          g  = $urandom_range(0, 1) ? G_MAX : G_MIN;
          sh = $urandom_range(0, 1) ? '0 : '1;
        end
        1: begin
          g  = $urandom;
          sh = GSH_BITS'($urandom_range(0, 63));
        end
        default: begin
          g  = $urandom;
          sh = GSH_BITS'($urandom_range(6, 24));
        end
      endcase
      load_filter(g, sh);
      quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 120);
      for (int k = 0; k < n; k++) begin
        send_pair(pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
        // Occasional pause mid-phase until the block has emptied
        if (k == n / 2 && $urandom_range(0, 2) == 0) begin
          drain();
          if ($urandom_range(0, 1) == 0) poke_unknown();
        end
      end
      drain();
      quiet = 1'b0;
    end

    // Wait out the tail, bounded
    s_axis_tvalid <= 1'b0;
    for (int k = 0; k < 10000 && tracker.awaited.size() != 0; k++) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (tracker.awaited.size() != 0) begin
      $error("%0d filtered pairs never came out", tracker.awaited.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ butterworth_biquad_cascade_2ch_unit.f @@
rtl/bbc2_pkg.sv
rtl/bbc2_ctrl.sv
rtl/bbc2_dp.sv
rtl/butterworth_biquad_cascade_2ch_unit.sv
rtl/bbc2_chk.sv
test/butterworth_biquad_cascade_2ch_unit_tb.sv
